// ===== hdl/dalirx_pkg.sv =====
// shared types and constants of the dali forward frame receiver
// no dependencies; used by every module of the block by scoped names
`timescale 1ns / 1ps

package dalirx_pkg;

	localparam int TICK_W = 16;
	localparam int BYTE_W = 8;
	localparam int CFG_IDX_W = 2;

	// pulse length classes, tested in this order
	typedef enum logic [2:0] {
		CL_SHORT,
		CL_HALF,
		CL_MIDDLE,
		CL_FULL,
		CL_LONG
	} pulse_class_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_MID,
		PH_HALF,
		PH_WAIT
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_HALF_MIN,
		REG_HALF_MAX,
		REG_FULL_MIN,
		REG_FULL_MAX
	} cfg_reg_t;

	typedef enum logic {
		ST_OK = 1'b0,
		ST_CORRUPT = 1'b1
	} frame_status_t;

	localparam logic [TICK_W-1:0] HALF_MIN_RST = 16'd333;
	localparam logic [TICK_W-1:0] HALF_MAX_RST = 16'd500;
	localparam logic [TICK_W-1:0] FULL_MIN_RST = 16'd667;
	localparam logic [TICK_W-1:0] FULL_MAX_RST = 16'd1000;

	typedef struct packed {
		logic [TICK_W-1:0] half_min;
		logic [TICK_W-1:0] half_max;
		logic [TICK_W-1:0] full_min;
		logic [TICK_W-1:0] full_max;
	} thresholds_t;

endpackage

// ===== hdl/dali_forward_frame_receiver.sv =====
// top level of the dali forward frame receiver: input stage and assertions
// depends on dalirx_pkg, dalirx_cfg, dalirx_class, dalirx_fsm
`timescale 1ns / 1ps

// Decodes a DALI forward frame from measured bus pulses, one pulse word per
// clock while pulse_stall is low. A pulse word is classed against the four
// threshold registers as it enters the input register, and the decode state
// machine updates its phase, last bit and frame shifter from that register
// once the result register can take a word, writing any frame result (OK
// with address and command bytes, or CORRUPT with zero bytes) into the
// result register. pulse_stall rises only when the input register is full
// and the result register holds a word that the receiver stalls. Thresholds
// are written through the cfg port, which is always ready; the user must
// write them only while no pulse is in flight, as the block does not
// enforce this.

module dali_forward_frame_receiver #(
	parameter int FRAME_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pulse_valid,
	output logic                                pulse_stall,
	input  logic [dalirx_pkg::TICK_W-1:0]       pulse_ticks,
	input  logic                                pulse_level,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                status,
	output logic [dalirx_pkg::BYTE_W-1:0]       address_byte,
	output logic [dalirx_pkg::BYTE_W-1:0]       command_byte,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dalirx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dalirx_pkg::TICK_W-1:0]       cfg_data
);

	dalirx_pkg::thresholds_t thr;
	dalirx_pkg::pulse_class_t pclass;
	dalirx_pkg::pulse_class_t class_s1;
	logic level_s1;
	logic valid_s1;
	logic take;
	logic accept;

	assign cfg_ready = 1'b1;

	dalirx_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.thr       (thr)
	);

	dalirx_class u_class (
		.ticks  (pulse_ticks),
		.thr    (thr),
		.pclass (pclass)
	);

	assign pulse_stall = valid_s1 && !take;
	assign accept = pulse_valid && !pulse_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			class_s1 <= pclass;
			level_s1 <= pulse_level;
		end
	end

	dalirx_fsm #(
		.FRAME_BITS (FRAME_BITS)
	) u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.class_s1     (class_s1),
		.level_s1     (level_s1),
		.take         (take),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.address_byte (address_byte),
		.command_byte (command_byte)
	);

	// a corrupt frame never carries received bits
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status |-> address_byte == '0 && command_byte == '0)
		else $error("corrupt result with nonzero bytes");

	// input stalls only while the input register is full
	assert property (@(posedge clk) disable iff (!arst_n)
		pulse_stall |-> valid_s1)
		else $error("pulse stalled with empty input register");

	// an accepted word is in the input register next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		pulse_valid && !pulse_stall |=> valid_s1)
		else $error("accepted pulse word lost");

endmodule

// ===== hdl/dalirx_cfg.sv =====
// threshold register file of the dali frame receiver
// depends on dalirx_pkg
`timescale 1ns / 1ps

module dalirx_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [dalirx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [dalirx_pkg::TICK_W-1:0]       cfg_data,
	output dalirx_pkg::thresholds_t             thr
);

	dalirx_pkg::thresholds_t thr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.half_min <= dalirx_pkg::HALF_MIN_RST;
			thr_q.half_max <= dalirx_pkg::HALF_MAX_RST;
			thr_q.full_min <= dalirx_pkg::FULL_MIN_RST;
			thr_q.full_max <= dalirx_pkg::FULL_MAX_RST;
		end else if (cfg_valid) begin
			unique case (dalirx_pkg::cfg_reg_t'(cfg_index))
				dalirx_pkg::REG_HALF_MIN: thr_q.half_min <= cfg_data;
				dalirx_pkg::REG_HALF_MAX: thr_q.half_max <= cfg_data;
				dalirx_pkg::REG_FULL_MIN: thr_q.full_min <= cfg_data;
				dalirx_pkg::REG_FULL_MAX: thr_q.full_max <= cfg_data;
				default: thr_q <= thr_q;
			endcase
		end
	end

	assign thr = thr_q;

endmodule

// ===== hdl/dalirx_class.sv =====
// pulse length classifier: four compares against the threshold registers
// depends on dalirx_pkg
`timescale 1ns / 1ps

module dalirx_class (
	input  logic [dalirx_pkg::TICK_W-1:0] ticks,
	input  dalirx_pkg::thresholds_t       thr,
	output dalirx_pkg::pulse_class_t      pclass
);

	// priority order keeps misordered thresholds well defined
	always_comb begin
		if (ticks < thr.half_min)
			pclass = dalirx_pkg::CL_SHORT;
		else if (ticks <= thr.half_max)
			pclass = dalirx_pkg::CL_HALF;
		else if (ticks <= thr.full_min)
			pclass = dalirx_pkg::CL_MIDDLE;
		else if (ticks <= thr.full_max)
			pclass = dalirx_pkg::CL_FULL;
		else
			pclass = dalirx_pkg::CL_LONG;
	end

endmodule

// ===== hdl/dalirx_fsm.sv =====
// manchester decode state machine with frame shifter and result register
// depends on dalirx_pkg
`timescale 1ns / 1ps

module dalirx_fsm #(
	parameter int FRAME_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                valid_s1,
	input  dalirx_pkg::pulse_class_t            class_s1,
	input  logic                                level_s1,
	output logic                                take,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                status,
	output logic [dalirx_pkg::BYTE_W-1:0]       address_byte,
	output logic [dalirx_pkg::BYTE_W-1:0]       command_byte
);

	dalirx_pkg::phase_t phase_q, phase_d;
	logic prev_bit_q, prev_bit_d;
	logic [FRAME_BITS-1:0] shifter_q, shifter_d;
	logic emit;
	dalirx_pkg::frame_status_t emit_status;
	logic fire;

	logic result_valid_q;
	logic status_q;
	logic [dalirx_pkg::BYTE_W-1:0] address_q, command_q;

	assign take = !(result_valid_q && result_stall);
	assign fire = valid_s1 && take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dalirx_pkg::PH_IDLE;
			prev_bit_q <= 1'b1;
			shifter_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			prev_bit_q <= prev_bit_d;
			shifter_q <= shifter_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		prev_bit_d = prev_bit_q;
		shifter_d = shifter_q;
		emit = 1'b0;
		emit_status = dalirx_pkg::ST_CORRUPT;
		unique case (phase_q)
			dalirx_pkg::PH_IDLE: begin
				if (!level_s1) begin
					if (class_s1 == dalirx_pkg::CL_HALF) begin
						prev_bit_d = 1'b1;
						shifter_d = '0;
						phase_d = dalirx_pkg::PH_MID;
					end else begin
						emit = 1'b1;
					end
				end
			end
			dalirx_pkg::PH_MID: begin
				if (class_s1 == dalirx_pkg::CL_HALF) begin
					phase_d = dalirx_pkg::PH_HALF;
				end else if (class_s1 == dalirx_pkg::CL_FULL) begin
					// full bit toggles the bit value
					prev_bit_d = !prev_bit_q;
					shifter_d = {shifter_q[FRAME_BITS-2:0], !prev_bit_q};
				end else begin
					emit = 1'b1;
					if (class_s1 == dalirx_pkg::CL_LONG && level_s1 && prev_bit_q)
						emit_status = dalirx_pkg::ST_OK;
				end
			end
			dalirx_pkg::PH_HALF: begin
				if (class_s1 == dalirx_pkg::CL_HALF) begin
					// two halves repeat the bit value
					shifter_d = {shifter_q[FRAME_BITS-2:0], prev_bit_q};
					phase_d = dalirx_pkg::PH_MID;
				end else begin
					emit = 1'b1;
					if (class_s1 == dalirx_pkg::CL_LONG && level_s1 && !prev_bit_q)
						emit_status = dalirx_pkg::ST_OK;
				end
			end
			dalirx_pkg::PH_WAIT: begin
				if (level_s1)
					phase_d = dalirx_pkg::PH_IDLE;
			end
			default: phase_d = dalirx_pkg::PH_IDLE;
		endcase
		if (emit) begin
			phase_d = (emit_status == dalirx_pkg::ST_OK) ? dalirx_pkg::PH_IDLE
				: dalirx_pkg::PH_WAIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			status_q <= emit_status;
			if (emit_status == dalirx_pkg::ST_OK) begin
				address_q <= shifter_q[FRAME_BITS-1 -: dalirx_pkg::BYTE_W];
				command_q <= shifter_q[dalirx_pkg::BYTE_W-1:0];
			end else begin
				address_q <= '0;
				command_q <= '0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign status = status_q;
	assign address_byte = address_q;
	assign command_byte = command_q;

endmodule

// ===== tb/tb_dali_forward_frame_receiver.sv =====
// testbench for dali_forward_frame_receiver: random and directed pulse words against a
// built-in frame decoder, random idling on the pulse and result channels, threshold changes between phases
// depends on dalirx_pkg and the rtl of the block
`timescale 1ns / 1ps

module tb_dali_forward_frame_receiver;
	import dalirx_pkg::*;

	localparam int FRAME_BITS = 16;
	localparam int PULSE_TARGET = 900;
	localparam int NUM_PHASES = 9;
	localparam int SETTLE_CYCLES = 4;
	localparam int CALM_ITEMS = 150;
	localparam int HOLD_CYCLES = 80;
	localparam int END_CYCLES = 10;
	localparam int CYCLE_LIMIT = 500000;

	typedef enum {ACT_PULSE, ACT_CFG, ACT_DRAIN, ACT_HOLD} bus_act_t;
	typedef enum {FAULT_NONE, FAULT_TICKS, FAULT_LEVEL, FAULT_CUT} frame_fault_t;

	typedef struct {
		bus_act_t kind;
		logic [TICK_W-1:0] ticks;
		logic level;
		cfg_reg_t idx;
		logic [TICK_W-1:0] data;
	} bus_item_t;

	typedef struct {
		frame_status_t st;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] cmd;
	} frame_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic pulse_valid = 1'b0;
	logic pulse_stall;
	logic [TICK_W-1:0] pulse_ticks = '0;
	logic pulse_level = 1'b0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic status;
	logic [BYTE_W-1:0] address_byte;
	logic [BYTE_W-1:0] command_byte;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TICK_W-1:0] cfg_data = '0;

	dali_forward_frame_receiver #(
		.FRAME_BITS(FRAME_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.pulse_valid(pulse_valid),
		.pulse_stall(pulse_stall),
		.pulse_ticks(pulse_ticks),
		.pulse_level(pulse_level),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.address_byte(address_byte),
		.command_byte(command_byte),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// decoder copy: thresholds and frame state as seen at accepted words
	thresholds_t thr;
	phase_t ph;
	logic prev_bit;
	logic [FRAME_BITS-1:0] shifter;
	frame_t frame_q[$];

	// stimulus side
	thresholds_t gen_thr;
	bus_item_t bus_q[$];
	int planned = 0;
	bit stim_done = 1'b0;
	bit pulse_acc = 1'b0;
	bit cfg_acc = 1'b0;
	logic calm = 1'b0;
	int hold_req = 0;
	int gap_left = 0;
	int settle = 0;
	bit draining = 1'b0;
	int tx_rate = 10;
	int rx_rate = 10;
	int rx_gap = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycles = 0;

	task automatic close_frame(input frame_status_t st);
		frame_t f;
		f.st = st;
		if (st == ST_OK) begin
			f.addr = shifter[FRAME_BITS-1 -: BYTE_W];
			f.cmd = shifter[BYTE_W-1:0];
			ph = PH_IDLE;
		end else begin
			f.addr = '0;
			f.cmd = '0;
			ph = PH_WAIT;
		end
		frame_q.push_back(f);
	endtask

	task automatic decode_pulse(input logic [TICK_W-1:0] t, input logic lv);
		pulse_class_t c;
		if (t < thr.half_min)
			c = CL_SHORT;
		else if (t <= thr.half_max)
			c = CL_HALF;
		else if (t <= thr.full_min)
			c = CL_MIDDLE;
		else if (t <= thr.full_max)
			c = CL_FULL;
		else
			c = CL_LONG;
		case (ph)
			PH_IDLE: begin
				if (!lv) begin
					if (c == CL_HALF) begin
						prev_bit = 1'b1;
						shifter = '0;
						ph = PH_MID;
					end else
						close_frame(ST_CORRUPT);
				end
			end
			PH_MID: begin
				if (c == CL_HALF)
					ph = PH_HALF;
				else if (c == CL_FULL) begin
					prev_bit = !prev_bit;
					shifter = {shifter[FRAME_BITS-2:0], prev_bit};
				end else if (c == CL_LONG && lv && prev_bit)
					close_frame(ST_OK);
				else
					close_frame(ST_CORRUPT);
			end
			PH_HALF: begin
				if (c == CL_HALF) begin
					shifter = {shifter[FRAME_BITS-2:0], prev_bit};
					ph = PH_MID;
				end else if (c == CL_LONG && lv && !prev_bit)
					close_frame(ST_OK);
				else
					close_frame(ST_CORRUPT);
			end
			default: begin
				if (lv)
					ph = PH_IDLE;
			end
		endcase
	endtask

	task automatic push_pulse(input logic [TICK_W-1:0] t, input logic lv, input bit counts);
		bus_item_t w;
		w.kind = ACT_PULSE;
		w.ticks = t;
		w.level = lv;
		w.idx = REG_HALF_MIN;
		w.data = '0;
		bus_q.push_back(w);
		if (counts)
			planned++;
	endtask

	task automatic push_ctrl(input bus_act_t k, input cfg_reg_t idx, input logic [TICK_W-1:0] d);
		bus_item_t w;
		w.kind = k;
		w.ticks = '0;
		w.level = 1'b0;
		w.idx = idx;
		w.data = d;
		bus_q.push_back(w);
	endtask

	// thresholds only change with nothing in flight
	task automatic push_settings(input thresholds_t s);
		push_ctrl(ACT_DRAIN, REG_HALF_MIN, '0);
		push_ctrl(ACT_CFG, REG_HALF_MIN, s.half_min);
		push_ctrl(ACT_CFG, REG_HALF_MAX, s.half_max);
		push_ctrl(ACT_CFG, REG_FULL_MIN, s.full_min);
		push_ctrl(ACT_CFG, REG_FULL_MAX, s.full_max);
		push_ctrl(ACT_DRAIN, REG_HALF_MIN, '0);
		gen_thr = s;
	endtask

	// tick range that lands in a class, given the order of the compares
	function automatic void class_bounds(input pulse_class_t c, output int lo, output int hi);
		int h_lo, h_hi, f_lo, f_hi, l_lo, fm;
		h_lo = gen_thr.half_min;
		h_hi = gen_thr.half_max;
		fm = gen_thr.full_min;
		f_hi = gen_thr.full_max;
		f_lo = h_hi + 1;
		if (h_lo > f_lo)
			f_lo = h_lo;
		if (fm + 1 > f_lo)
			f_lo = fm + 1;
		l_lo = f_lo;
		if (f_hi + 1 > l_lo)
			l_lo = f_hi + 1;
		case (c)
			CL_HALF: begin
				lo = h_lo;
				hi = h_hi;
			end
			CL_FULL: begin
				lo = f_lo;
				hi = f_hi;
			end
			default: begin
				lo = l_lo;
				hi = 65535;
			end
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] pick_in(input pulse_class_t c);
		int lo, hi;
		class_bounds(c, lo, hi);
		case ($urandom_range(0, 3))
			0: return lo[TICK_W-1:0];
			1: return hi[TICK_W-1:0];
			default: return TICK_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] noise_ticks();
		int th;
		case ($urandom_range(0, 3))
			0: th = gen_thr.half_min;
			1: th = gen_thr.half_max;
			2: th = gen_thr.full_min;
			default: th = gen_thr.full_max;
		endcase
		th = th + int'($urandom_range(0, 40)) - 20;
		if (th < 0)
			th = 0;
		if (th > 65535)
			th = 65535;
		case ($urandom_range(0, 5))
			0, 1: return TICK_W'($urandom);
			2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			3: return TICK_W'($urandom_range(0, 1200));
			default: return th[TICK_W-1:0];
		endcase
	endfunction

	// manchester halves of start bit and data bits, merged into line pulses
	task automatic push_frame(input int nbits, input logic [31:0] bits, input frame_fault_t fault);
		logic hv [0:49];
		logic [TICK_W-1:0] pt[$];
		logic pl[$];
		int nh, i, j, k;
		logic d;
		hv[0] = 1'b0;
		hv[1] = 1'b1;
		for (i = 0; i < nbits; i++) begin
			d = bits[nbits-1-i];
			hv[2+2*i] = !d;
			hv[3+2*i] = d;
		end
		nh = 2 * nbits + 2;
		i = 0;
		while (i < nh) begin
			j = i;
			while (j + 1 < nh && hv[j+1] == hv[i])
				j++;
			pl.push_back(hv[i]);
			if (j == nh - 1 && hv[i])
				pt.push_back(pick_in(CL_LONG));
			else if (j == i)
				pt.push_back(pick_in(CL_HALF));
			else
				pt.push_back(pick_in(CL_FULL));
			i = j + 1;
		end
		// stop condition: line back high for longer than a full bit
		if (!hv[nh-1]) begin
			pl.push_back(1'b1);
			pt.push_back(pick_in(CL_LONG));
		end
		k = $urandom_range(0, pt.size() - 1);
		case (fault)
			FAULT_TICKS: pt[k] = noise_ticks();
			FAULT_LEVEL: pl[k] = !pl[k];
			FAULT_CUT: begin
				while (pt.size() > k) begin
					void'(pt.pop_back());
					void'(pl.pop_back());
				end
			end
			default: ;
		endcase
		foreach (pt[n])
			push_pulse(pt[n], pl[n], 1'b1);
	endtask

	initial begin : stimulus
		thresholds_t plan [0:NUM_PHASES-1];
		int target, lo, hi, flo, fhi, a, b, c, e, nb, n;
		bit framable, full_ok, paused;
		logic [31:0] bits;
		logic lv;
		frame_fault_t f;

		thr = {HALF_MIN_RST, HALF_MAX_RST, FULL_MIN_RST, FULL_MAX_RST};
		gen_thr = thr;
		ph = PH_IDLE;
		prev_bit = 1'b1;
		shifter = '0;
		paused = 1'b0;

		a = $urandom_range(1, 2000);
		b = a + $urandom_range(0, 500);
		c = b + $urandom_range(1, 1000);
		e = c + $urandom_range(1, 3000);
		plan[0] = thr;
		plan[1] = {16'd300, 16'd450, 16'd700, 16'd1100};
		plan[2] = {16'd0, 16'd0, 16'd0, 16'd0};
		plan[3] = {16'd1, 16'd2, 16'd3, 16'd4};
		plan[4] = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		plan[5] = {16'd1000, 16'd500, 16'd667, 16'd333};
		plan[6] = {16'd10, 16'd20, 16'd40, 16'd65534};
		plan[7] = {a[15:0], b[15:0], c[15:0], e[15:0]};
		plan[8] = thr;

		// directed words at the reset thresholds
		push_pulse(16'hFFFF, 1'b1, 1'b0);	// high in idle is ignored
		push_pulse(16'd0, 1'b0, 1'b1);		// too short low opens nothing
		push_pulse(16'd500, 1'b0, 1'b0);	// low while waiting for high
		push_pulse(16'd0, 1'b1, 1'b1);
		push_pulse(16'd667, 1'b0, 1'b1);	// in between low in idle
		push_pulse(16'd1000, 1'b1, 1'b1);
		push_pulse(16'd333, 1'b0, 1'b1);
		push_pulse(16'd1000, 1'b1, 1'b1);
		push_pulse(16'd668, 1'b0, 1'b1);
		push_pulse(16'd500, 1'b1, 1'b1);
		push_pulse(16'd800, 1'b0, 1'b1);	// full bit after a first half bit
		push_pulse(16'hFFFF, 1'b1, 1'b1);
		push_pulse(16'd400, 1'b0, 1'b1);
		push_pulse(16'd332, 1'b1, 1'b1);	// too short inside a frame
		push_pulse(16'd7, 1'b1, 1'b1);
		push_pulse(16'd500, 1'b0, 1'b1);
		push_pulse(16'd1001, 1'b1, 1'b1);	// empty frame closes ok
		push_pulse(16'd333, 1'b0, 1'b1);
		push_pulse(16'd333, 1'b1, 1'b1);
		push_pulse(16'd2000, 1'b1, 1'b1);	// stop with the wrong last bit
		push_pulse(16'd5000, 1'b1, 1'b1);
		push_pulse(16'd400, 1'b0, 1'b1);
		push_pulse(16'd1001, 1'b0, 1'b1);	// too long but low
		push_pulse(16'd1, 1'b1, 1'b1);

		push_ctrl(ACT_HOLD, REG_HALF_MIN, '0);
		planned = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				push_settings(plan[p]);
			target = (p + 1) * PULSE_TARGET / NUM_PHASES;
			class_bounds(CL_HALF, lo, hi);
			class_bounds(CL_LONG, flo, fhi);
			framable = lo <= hi && flo <= fhi;
			class_bounds(CL_FULL, flo, fhi);
			full_ok = flo <= fhi;
			while (planned < target) begin
				if (p == 3 && !paused && planned > target - 50) begin
					push_ctrl(ACT_DRAIN, REG_HALF_MIN, '0);
					paused = 1'b1;
				end
				n = $urandom_range(0, 99);
				if (framable && n < 85) begin
					nb = ($urandom_range(0, 9) < 8) ? FRAME_BITS : $urandom_range(1, 24);
					case ($urandom_range(0, 9))
						0: bits = '0;
						1: bits = '1;
						default: bits = $urandom;
					endcase
					// without a full bit class only all-ones frames can be sent
					if (!full_ok)
						bits = '1;
					if (n < 70)
						f = FAULT_NONE;
					else begin
						case ($urandom_range(0, 2))
							0: f = FAULT_TICKS;
							1: f = FAULT_LEVEL;
							default: f = FAULT_CUT;
						endcase
					end
					push_frame(nb, bits, f);
				end else begin
					repeat ($urandom_range(1, 4)) begin
						lv = $urandom_range(0, 9) < 3;
						push_pulse(noise_ticks(), lv, !lv);
					end
				end
			end
		end

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		wait (stim_done && frame_q.size() == 0);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatches == 0 && frame_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// pulse and threshold channels, driven on the falling edge
	always @(negedge clk) begin : drive
		bus_item_t w;
		logic p_busy, c_busy, nv, ncv;
		p_busy = pulse_valid && !pulse_acc;
		c_busy = cfg_valid && !cfg_acc;
		nv = p_busy;
		ncv = c_busy;
		if (arst_n && !p_busy && !c_busy) begin
			if (gap_left > 0)
				gap_left--;
			else if (draining) begin
				settle = (frame_q.size() == 0) ? settle + 1 : 0;
				if (settle >= SETTLE_CYCLES)
					draining = 1'b0;
			end else if (bus_q.size() == 0)
				stim_done = 1'b1;
			else if (bus_q[0].kind == ACT_PULSE && !calm && $urandom_range(0, 99) < tx_rate)
				gap_left = $urandom_range(0, 11);
			else begin
				w = bus_q.pop_front();
				case (w.kind)
					ACT_PULSE: begin
						nv = 1'b1;
						pulse_ticks <= w.ticks;
						pulse_level <= w.level;
						if ($urandom_range(0, 149) == 0)
							tx_rate = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 35);
					end
					ACT_CFG: begin
						ncv = 1'b1;
						cfg_index <= w.idx;
						cfg_data <= w.data;
					end
					ACT_DRAIN: begin
						draining = 1'b1;
						settle = 0;
					end
					default: hold_req <= hold_req + 1;
				endcase
			end
		end
		pulse_valid <= nv;
		cfg_valid <= ncv;
		calm <= bus_q.size() < CALM_ITEMS;
	end

	// result side: random stall bursts, plus one long hold-off on request
	always @(negedge clk) begin : receive
		logic st;
		st = 1'b0;
		if (arst_n) begin
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if ($urandom_range(0, 199) == 0)
				rx_rate = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(5, 35);
			if (hold_left > 0) begin
				hold_left--;
				st = 1'b1;
			end else if (rx_gap > 0) begin
				rx_gap--;
				st = 1'b1;
			end else if (!calm && $urandom_range(0, 99) < rx_rate) begin
				rx_gap = $urandom_range(0, 11);
				st = 1'b1;
			end
		end
		result_stall <= st;
	end

	always @(posedge clk) begin : observe
		frame_t want;
		pulse_acc = 1'b0;
		cfg_acc = 1'b0;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				if (frame_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: status %0d address %02h command %02h",
							status, address_byte, command_byte);
				end else begin
					want = frame_q.pop_front();
					if (status !== want.st || address_byte !== want.addr
							|| command_byte !== want.cmd) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch at %0t: status %0d/%0d address %02h/%02h %s%02h/%02h",
								$realtime, want.st, status, want.addr, address_byte,
								"command ", want.cmd, command_byte);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				cfg_acc = 1'b1;
				case (cfg_index)
					REG_HALF_MIN: thr.half_min = cfg_data;
					REG_HALF_MAX: thr.half_max = cfg_data;
					REG_FULL_MIN: thr.full_min = cfg_data;
					default: thr.full_max = cfg_data;
				endcase
			end
			if (pulse_valid && !pulse_stall) begin
				pulse_acc = 1'b1;
				decode_pulse(pulse_ticks, pulse_level);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles, frame_q.size());
			$display("FAIL");
			$finish;
		end
	end

endmodule
